// ===== hw/rtl/mfp_pkg.sv =====
// ----------------------------------------------------------------------------
// mfp_pkg
// Shared types and constants for the MSP v2 frame parser: result record,
// result kinds and direction codes.
// ----------------------------------------------------------------------------
`default_nettype none

package mfp_pkg;

  // Largest payload that is forwarded beat by beat; later bytes are only CRC'd
  localparam int unsigned MaxPayload = 256;

  // Result kinds (carried on tuser)
  localparam logic [1:0] KindPayload = 2'd0;
  localparam logic [1:0] KindGood    = 2'd1;
  localparam logic [1:0] KindBad     = 2'd2;

  // Direction codes
  localparam logic [1:0] DirRequest  = 2'd0;
  localparam logic [1:0] DirResponse = 2'd1;
  localparam logic [1:0] DirError    = 2'd2;

  // Header characters
  localparam logic [7:0] ChDollar = 8'h24;  // '$'
  localparam logic [7:0] ChX      = 8'h58;  // 'X'
  localparam logic [7:0] ChLt     = 8'h3C;  // '<'
  localparam logic [7:0] ChGt     = 8'h3E;  // '>'
  localparam logic [7:0] ChBang   = 8'h21;  // '!'

  // Packed tdata width of one result beat (59 bits of fields, padded)
  localparam int unsigned OutDataW = 64;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic [7:0]  payload_position;
    logic [15:0] function_code;
    logic [15:0] frame_length;
    logic [1:0]  direction_code;
    logic [7:0]  flag_bits;
    logic        oversize;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mfp_front.sv =====
// ----------------------------------------------------------------------------
// mfp_front
// Frame parser front end: accepts one byte per cycle while the result queue
// is not full, tracks the header and payload phases, runs the CRC-8/DVB-S2
// and classifies each byte into an optional result record for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module mfp_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [7:0]       in_byte_i,
  input  wire logic             q_full_i,
  output logic                  push_o,
  output mfp_pkg::result_t      push_data_o
);
  import mfp_pkg::*;

  typedef enum logic [3:0] {
    PhIdle    = 4'd0,
    PhDollar  = 4'd1,
    PhX       = 4'd2,
    PhFlags   = 4'd3,
    PhFuncL   = 4'd4,
    PhFuncH   = 4'd5,
    PhSizeL   = 4'd6,
    PhSizeH   = 4'd7,
    PhPayload = 4'd8,
    PhCheck   = 4'd9
  } phase_e;

  // One byte through the 0xD5 polynomial, MSB first
  function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ 8'hD5) : (c << 1);
    end
    return c;
  endfunction

  phase_e      phase_q, phase_d;
  logic [7:0]  crc_q, crc_d;
  logic [15:0] func_q, func_d;
  logic [15:0] size_q, size_d;
  logic [15:0] count_q, count_d;
  logic [1:0]  dir_q, dir_d;
  logic [7:0]  flags_q, flags_d;

  logic        accept;
  logic [7:0]  crc_next;
  logic [16:0] count_inc;
  logic        oversize;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign crc_next   = crc_byte(crc_q, in_byte_i);
  assign count_inc  = {1'b0, count_q} + 17'd1;
  assign oversize   = ({1'b0, size_q} > 17'(MaxPayload));

  // Phase and field update, result classification
  always_comb begin
    phase_d = phase_q;
    crc_d   = crc_q;
    func_d  = func_q;
    size_d  = size_q;
    count_d = count_q;
    dir_d   = dir_q;
    flags_d = flags_q;
    push_o  = 1'b0;

    push_data_o.kind             = KindPayload;
    push_data_o.payload_byte     = 8'd0;
    push_data_o.payload_position = 8'd0;
    push_data_o.function_code    = func_q;
    push_data_o.frame_length     = size_q;
    push_data_o.direction_code   = dir_q;
    push_data_o.flag_bits        = flags_q;
    push_data_o.oversize         = oversize;

    case (phase_q)
      PhIdle: begin
        if (in_byte_i == ChDollar) begin
          phase_d = PhDollar;
          crc_d   = 8'd0;
        end
      end
      PhDollar: begin
        phase_d = (in_byte_i == ChX) ? PhX : PhIdle;
      end
      PhX: begin
        phase_d = PhFlags;
        if (in_byte_i == ChLt) begin
          dir_d = DirRequest;
        end else if (in_byte_i == ChGt) begin
          dir_d = DirResponse;
        end else if (in_byte_i == ChBang) begin
          dir_d = DirError;
        end else begin
          phase_d = PhIdle;
        end
      end
      PhFlags: begin
        flags_d = in_byte_i;
        crc_d   = crc_next;
        phase_d = PhFuncL;
      end
      PhFuncL: begin
        func_d  = {8'd0, in_byte_i};
        crc_d   = crc_next;
        phase_d = PhFuncH;
      end
      PhFuncH: begin
        func_d  = {in_byte_i, func_q[7:0]};
        crc_d   = crc_next;
        phase_d = PhSizeL;
      end
      PhSizeL: begin
        size_d  = {8'd0, in_byte_i};
        crc_d   = crc_next;
        phase_d = PhSizeH;
      end
      PhSizeH: begin
        size_d  = {in_byte_i, size_q[7:0]};
        crc_d   = crc_next;
        count_d = 16'd0;
        phase_d = ({in_byte_i, size_q[7:0]} != 16'd0) ? PhPayload : PhCheck;
      end
      PhPayload: begin
        crc_d   = crc_next;
        count_d = count_inc[15:0];
        if ({1'b0, count_q} < 17'(MaxPayload)) begin
          push_o                       = accept;
          push_data_o.kind             = KindPayload;
          push_data_o.payload_byte     = in_byte_i;
          push_data_o.payload_position = count_q[7:0];
        end
        if (count_inc >= {1'b0, size_q}) begin
          phase_d = PhCheck;
        end
      end
      PhCheck: begin
        push_o           = accept;
        push_data_o.kind = (in_byte_i == crc_q) ? KindGood : KindBad;
        phase_d          = PhIdle;
      end
      default: begin
        phase_d = PhIdle;
      end
    endcase
  end

  // State registers, advanced on each accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      crc_q   <= 8'd0;
      func_q  <= 16'd0;
      size_q  <= 16'd0;
      count_q <= 16'd0;
      dir_q   <= 2'd0;
      flags_q <= 8'd0;
    end else if (accept) begin
      phase_q <= phase_d;
      crc_q   <= crc_d;
      func_q  <= func_d;
      size_q  <= size_d;
      count_q <= count_d;
      dir_q   <= dir_d;
      flags_q <= flags_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mfp_queue.sv =====
// ----------------------------------------------------------------------------
// mfp_queue
// Short result queue between the parser front end and the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module mfp_queue #(
  parameter int unsigned Depth = 4
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire mfp_pkg::result_t  push_data_i,
  output logic                   full_o,
  output logic                   valid_o,
  output mfp_pkg::result_t       data_o,
  input  wire logic              pop_i
);
  import mfp_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  result_t         mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mfp_back.sv =====
// ----------------------------------------------------------------------------
// mfp_back
// Output stage: pulls result records from the queue into a registered
// master-side beat and packs the fields for tdata and tuser.
// ----------------------------------------------------------------------------
`default_nettype none

module mfp_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          q_valid_i,
  input  wire mfp_pkg::result_t              q_data_i,
  output logic                               q_pop_o,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [mfp_pkg::OutDataW-1:0]       out_data_o,
  output logic [1:0]                         out_user_o
);
  import mfp_pkg::*;

  logic    valid_q;
  result_t res_q;

  // Load whenever the output register is empty or being drained
  assign q_pop_o = q_valid_i && (!valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!valid_q || out_ready_i) begin
      valid_q <= q_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      res_q <= q_data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_user_o  = res_q.kind;
  assign out_data_o  = {5'd0, res_q.oversize, res_q.flag_bits, res_q.direction_code,
                        res_q.frame_length, res_q.function_code,
                        res_q.payload_position, res_q.payload_byte};

endmodule

`default_nettype wire

// ===== hw/rtl/msp_v2_frame_parser.sv =====
// Path: a result beat reaches the master side from the front-end classify
// through the queue and then the output register after its byte is accepted.
// Throughput: one byte per cycle; the slave side stalls only when the result
// queue is full, which happens only while the master side is held off.
// Reset: asynchronous, active low; parser returns to idle, CRC and frame fields
// clear, queue and output register empty. No clearing pass is needed.
// ----------------------------------------------------------------------------
// msp_v2_frame_parser
// MSP v2 frame parser with CRC-8/DVB-S2 check: emits payload beats and a
// frame good/bad beat per frame.
// ----------------------------------------------------------------------------
`default_nettype none

module msp_v2_frame_parser #(
  parameter int unsigned QueueDepth = 4
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Slave side
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  wire logic [7:0]                    s_axis_tdata_i,  // [7:0] rx_byte
  // Master side
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  // [7:0] payload_byte, [15:8] payload_position, [31:16] function_code,
  // [47:32] frame_length, [49:48] direction_code, [57:50] flag_bits,
  // [58] oversize, [63:59] zero
  output logic [mfp_pkg::OutDataW-1:0]       m_axis_tdata_o,
  output logic [1:0]                         m_axis_tuser_o   // [1:0] result_kind
);
  import mfp_pkg::*;

  logic    q_full, q_valid, q_pop, push;
  result_t push_data, q_data;

  mfp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_byte_i   (s_axis_tdata_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  mfp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .data_o      (q_data),
    .pop_i       (q_pop)
  );

  mfp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o),
    .out_user_o  (m_axis_tuser_o)
  );

endmodule

`default_nettype wire

// ===== tb/sv/msp_v2_frame_parser_checker.sv =====
// ----------------------------------------------------------------------------
// msp_v2_frame_parser_checker
// Passive checker for the MSP v2 frame parser. It watches both stream
// channels and keeps its own copy of the parser state. Every accepted byte
// goes through that copy. The result beats it predicts wait in an ordered
// queue, and each beat the block hands over is checked field by field
// against the oldest of them.
// ----------------------------------------------------------------------------
module msp_v2_frame_parser_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_tvalid_i,
  input  logic                         s_tready_i,
  input  logic [7:0]                   s_tdata_i,
  input  logic                         m_tvalid_i,
  input  logic                         m_tready_i,
  input  logic [mfp_pkg::OutDataW-1:0] m_tdata_i,
  input  logic [1:0]                   m_tuser_i,
  input  logic                         end_check_i,
  output int                           error_count_o,
  output int                           pending_o,
  output int                           bytes_seen_o,
  output int                           payload_beats_o,
  output int                           good_frames_o,
  output int                           bad_frames_o,
  output int                           oversize_ends_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import mfp_pkg::*;

  typedef enum logic [3:0] {
    PhIdle, PhDollar, PhX, PhFlags, PhFuncL, PhFuncH, PhSizeL, PhSizeH,
    PhPayload, PhCheck
  } parse_phase_e;

  // Shadow copy of the parser state
  parse_phase_e phase_q;
  logic [7:0]   crc_q;
  logic [15:0]  func_q;
  logic [15:0]  size_q;
  logic [15:0]  count_q;
  logic [1:0]   dir_q;
  logic [7:0]   flags_q;

  result_t expected_beats[$];
  bit      end_seen;

  // CRC-8/DVB-S2, one byte, MSB first
  function automatic logic [7:0] crc_step(logic [7:0] crc, logic [7:0] d);
    logic [7:0] c;
    c = crc ^ d;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ 8'hD5) : (c << 1);
    end
    return c;
  endfunction

  // Result record carrying the current frame fields
  function automatic result_t frame_record(logic [1:0] kind, logic [7:0] pb,
                                           logic [7:0] pos);
    result_t r;
    r.kind             = kind;
    r.payload_byte     = pb;
    r.payload_position = pos;
    r.function_code    = func_q;
    r.frame_length     = size_q;
    r.direction_code   = dir_q;
    r.flag_bits        = flags_q;
    r.oversize         = (size_q > MaxPayload);
    return r;
  endfunction

  // Advance the shadow parser by one received byte
  task automatic parse_byte(input logic [7:0] b, output bit emit,
                            output result_t res);
    emit = 1'b0;
    res  = '0;
    case (phase_q)
      PhIdle: begin
        if (b == ChDollar) begin
          phase_q = PhDollar;
          crc_q   = '0;
        end
      end
      PhDollar: phase_q = (b == ChX) ? PhX : PhIdle;
      PhX: begin
        phase_q = PhFlags;
        if (b == ChLt) dir_q = DirRequest;
        else if (b == ChGt) dir_q = DirResponse;
        else if (b == ChBang) dir_q = DirError;
        else phase_q = PhIdle;
      end
      PhFlags: begin
        flags_q = b;
        crc_q   = crc_step(crc_q, b);
        phase_q = PhFuncL;
      end
      PhFuncL: begin
        func_q  = {8'h00, b};
        crc_q   = crc_step(crc_q, b);
        phase_q = PhFuncH;
      end
      PhFuncH: begin
        func_q[15:8] = b;
        crc_q        = crc_step(crc_q, b);
        phase_q      = PhSizeL;
      end
      PhSizeL: begin
        size_q  = {8'h00, b};
        crc_q   = crc_step(crc_q, b);
        phase_q = PhSizeH;
      end
      PhSizeH: begin
        size_q[15:8] = b;
        crc_q        = crc_step(crc_q, b);
        count_q      = '0;
        phase_q      = (size_q != 16'd0) ? PhPayload : PhCheck;
      end
      PhPayload: begin
        crc_q = crc_step(crc_q, b);
        // beyond the forwarding limit bytes are only counted and CRC'd
        if (count_q < MaxPayload) begin
          emit = 1'b1;
          res  = frame_record(KindPayload, b, count_q[7:0]);
        end
        count_q = count_q + 16'd1;
        if (count_q >= size_q) phase_q = PhCheck;
      end
      PhCheck: begin
        emit    = 1'b1;
        res     = frame_record((b == crc_q) ? KindGood : KindBad, 8'h00, 8'h00);
        phase_q = PhIdle;
      end
      default: phase_q = PhIdle;
    endcase
  endtask

  // One line per failure; printing is capped, counting is not
  task automatic report_error(input string msg);
    error_count_o++;
    if (error_count_o <= 30) $display("[%0t] ERROR: %s", $realtime, msg);
  endtask

  // Watch both channels on the rising edge
  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    result_t res;
    bit      emit;
    if (!rst_ni) begin
      phase_q         = PhIdle;
      crc_q           = '0;
      func_q          = '0;
      size_q          = '0;
      count_q         = '0;
      dir_q           = '0;
      flags_q         = '0;
      end_seen        = 1'b0;
      error_count_o   = 0;
      bytes_seen_o    = 0;
      payload_beats_o = 0;
      good_frames_o   = 0;
      bad_frames_o    = 0;
      oversize_ends_o = 0;
      expected_beats.delete();
    end else begin
      // result beat leaving the block
      if (m_tvalid_i && m_tready_i) begin
        got.kind             = m_tuser_i;
        got.payload_byte     = m_tdata_i[7:0];
        got.payload_position = m_tdata_i[15:8];
        got.function_code    = m_tdata_i[31:16];
        got.frame_length     = m_tdata_i[47:32];
        got.direction_code   = m_tdata_i[49:48];
        got.flag_bits        = m_tdata_i[57:50];
        got.oversize         = m_tdata_i[58];
        case (got.kind)
          KindPayload: payload_beats_o++;
          KindGood:    good_frames_o++;
          default:     bad_frames_o++;
        endcase
        if (got.kind != KindPayload && got.oversize) oversize_ends_o++;
        if (expected_beats.size() == 0) begin
          report_error($sformatf("unexpected result beat, kind %0d", got.kind));
        end else begin
          want = expected_beats.pop_front();
          if (got.kind !== want.kind)
            report_error($sformatf("result_kind %0d, expected %0d",
                                   got.kind, want.kind));
          if (got.payload_byte !== want.payload_byte)
            report_error($sformatf("payload_byte %02h, expected %02h",
                                   got.payload_byte, want.payload_byte));
          if (got.payload_position !== want.payload_position)
            report_error($sformatf("payload_position %0d, expected %0d",
                                   got.payload_position, want.payload_position));
          if (got.function_code !== want.function_code)
            report_error($sformatf("function_code %04h, expected %04h",
                                   got.function_code, want.function_code));
          if (got.frame_length !== want.frame_length)
            report_error($sformatf("frame_length %0d, expected %0d",
                                   got.frame_length, want.frame_length));
          if (got.direction_code !== want.direction_code)
            report_error($sformatf("direction_code %0d, expected %0d",
                                   got.direction_code, want.direction_code));
          if (got.flag_bits !== want.flag_bits)
            report_error($sformatf("flag_bits %02h, expected %02h",
                                   got.flag_bits, want.flag_bits));
          if (got.oversize !== want.oversize)
            report_error($sformatf("oversize %0d, expected %0d",
                                   got.oversize, want.oversize));
        end
      end
      // byte entering the block
      if (s_tvalid_i && s_tready_i) begin
        bytes_seen_o++;
        parse_byte(s_tdata_i, emit, res);
        if (emit) expected_beats.push_back(res);
      end
      // anything still queued at the end never arrived
      if (end_check_i && !end_seen) begin
        end_seen = 1'b1;
        if (expected_beats.size() != 0)
          report_error($sformatf("%0d expected result beats never arrived",
                                 expected_beats.size()));
      end
    end
    pending_o = expected_beats.size();
  end

endmodule

// ===== tb/sv/msp_v2_frame_parser_tb.sv =====
// ----------------------------------------------------------------------------
// msp_v2_frame_parser_tb
// Stimulus and verdict for the MSP v2 frame parser. A short directed run
// covers idle noise, broken headers, a zero-size frame and a corrupted
// frame. Random traffic follows, mostly well-formed frames with some noise
// and broken headers, under three idle mixes; the second mix opens with an
// oversize frame. Checking is left to the checker.
// ----------------------------------------------------------------------------
module msp_v2_frame_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mfp_pkg::*;

  // cycles without any accepted beat before the run is abandoned
  localparam int StallLimit = 2000;

  logic                clk;
  logic                rst_n;
  logic                s_tvalid;
  logic                s_tready;
  logic [7:0]          s_tdata;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;
  logic [1:0]          m_tuser;
  logic                end_check;

  int error_count, pending, bytes_seen, payload_beats;
  int good_frames, bad_frames, oversize_ends;
  int send_idle_pct, recv_idle_pct;
  int bytes_sent;
  int quiet_cycles;

  msp_v2_frame_parser dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  msp_v2_frame_parser_checker parse_check (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_tvalid_i      (s_tvalid),
    .s_tready_i      (s_tready),
    .s_tdata_i       (s_tdata),
    .m_tvalid_i      (m_tvalid),
    .m_tready_i      (m_tready),
    .m_tdata_i       (m_tdata),
    .m_tuser_i       (m_tuser),
    .end_check_i     (end_check),
    .error_count_o   (error_count),
    .pending_o       (pending),
    .bytes_seen_o    (bytes_seen),
    .payload_beats_o (payload_beats),
    .good_frames_o   (good_frames),
    .bad_frames_o    (bad_frames),
    .oversize_ends_o (oversize_ends)
  );

  // 2 ns clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver back-pressure, changed on the falling edge
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog on cycles with no accepted beat on either side
  always @(posedge clk) begin
    if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("Timeout: no beat accepted for %0d cycles", StallLimit);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one byte, with random gaps ahead of it; entered and left on a
  // falling edge
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
  endtask

  // Whole frame with random payload; corrupt spoils the check byte
  task automatic send_frame(input logic [1:0] dir, input logic [7:0] flags,
                            input logic [15:0] func, input logic [15:0] size,
                            input bit corrupt);
    logic [7:0] crc;
    logic [7:0] pb;
    logic [7:0] hdr[6];
    hdr = '{flags, func[7:0], func[15:8], size[7:0], size[15:8], 8'h00};
    send_byte(ChDollar);
    send_byte(ChX);
    case (dir)
      DirRequest:  send_byte(ChLt);
      DirResponse: send_byte(ChGt);
      default:     send_byte(ChBang);
    endcase
    crc = 8'h00;
    for (int i = 0; i < 5; i++) begin
      crc = parse_check.crc_step(crc, hdr[i]);
      send_byte(hdr[i]);
    end
    for (int i = 0; i < int'(size); i++) begin
      pb  = 8'($urandom);
      crc = parse_check.crc_step(crc, pb);
      send_byte(pb);
    end
    if (corrupt) crc = crc ^ 8'($urandom_range(1, 255));
    send_byte(crc);
  endtask

  // Mostly valid frames, with noise and broken headers mixed in
  task automatic random_traffic(input int byte_budget);
    int         first;
    int         pick;
    int         n;
    logic [7:0] b;
    logic [15:0] sz;
    first = bytes_sent;
    while (bytes_sent - first < byte_budget) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        // idle noise; a stray '$' here could lock onto a huge bogus size
        n = $urandom_range(1, 3);
        repeat (n) begin
          do b = 8'($urandom); while (b == ChDollar);
          send_byte(b);
        end
      end else if (pick < 12) begin
        send_byte(ChDollar);
        do b = 8'($urandom); while (b == ChX);
        send_byte(b);
      end else if (pick < 16) begin
        send_byte(ChDollar);
        send_byte(ChX);
        do b = 8'($urandom); while (b == ChLt || b == ChGt || b == ChBang);
        send_byte(b);
      end else begin
        sz = ($urandom_range(9) < 8) ? 16'($urandom_range(8))
                                     : 16'($urandom_range(9, 40));
        send_frame(2'($urandom_range(2)), 8'($urandom), 16'($urandom), sz,
                   $urandom_range(4) == 0);
      end
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    s_tvalid      = 1'b0;
    s_tdata       = 8'h00;
    end_check     = 1'b0;
    bytes_sent    = 0;
    send_idle_pct = 6;
    recv_idle_pct = 84;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: noise while idle, second '$' is not a restart,
    // bad direction byte, zero-size frame at the extremes, corrupted frame
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(ChDollar);
    send_byte(ChDollar);
    send_byte(ChX);
    send_byte(ChDollar);
    send_byte(ChX);
    send_byte(8'h3F);
    send_frame(DirRequest, 8'hFF, 16'hFFFF, 16'd0, 1'b0);
    send_frame(DirError, 8'h00, 16'h0000, 16'd1, 1'b1);

    // Receiver mostly stalled
    random_traffic(70);

    // Sender mostly idle; starts with an oversize frame
    send_idle_pct = 84;
    recv_idle_pct = 6;
    send_frame(DirResponse, 8'($urandom), 16'($urandom),
               16'(MaxPayload + 1 + $urandom_range(2)), 1'b1);
    random_traffic(70);

    // No idling: full-rate traffic
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_traffic(70);
    s_tvalid <= 1'b0;

    // Drain, then allow for the pipeline before the leftover check
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    end_check <= 1'b1;
    repeat (2) @(negedge clk);

    $display("Run covered %0d bytes in, %0d payload beats out, %0d good and %0d bad",
             bytes_seen, payload_beats, good_frames, bad_frames);
    $display("frame ends (%0d oversize), under three idle mixes; %0d errors",
             oversize_ends, error_count);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
